// ===== hw/rtl/krts_pkg.sv =====
`default_nettype none

package krts_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_ENQ_COMBO = 2'd1,
    CMD_ENQ_MEDIA = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_PRESS   = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_MEDIA   = 3'd2,
    ACT_ENQ     = 3'd3,
    ACT_FULL    = 3'd4
  } action_e;

  typedef enum logic {
    CFG_HOLD_TICKS = 1'b0,
    CFG_GAP_TICKS  = 1'b1
  } cfg_reg_e;

  localparam int unsigned CntWidth  = 10;
  localparam int unsigned CodeWidth = 16;

  localparam logic [CntWidth-1:0] HoldReset = 10'd14;
  localparam logic [CntWidth-1:0] GapReset  = 10'd8;

  typedef struct packed {
    logic                 media;
    logic [CodeWidth-1:0] code;
  } entry_t;

  typedef struct packed {
    logic space2;
    logic push0;
    logic push1;
  } rq_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/krts_result_fifo.sv =====
`default_nettype none

module krts_result_fifo
  import krts_pkg::*;
#(
  parameter int unsigned Width = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rq_ctrl_t         ctrl_i,
  output rq_ctrl_t              ctrl_o,
  input  wire logic [Width-1:0] data0_i,
  input  wire logic [Width-1:0] data1_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [Width-1:0]      out_data_o
);

  localparam int unsigned Depth = 4;

  logic [Width-1:0] mem_q [Depth];
  logic [1:0]       wr_ptr_q, wr_ptr_d;
  logic [1:0]       rd_ptr_q, rd_ptr_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             pop;

  assign pop         = (cnt_q != 3'd0) && !out_stall_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    ctrl_o        = ctrl_i;
    ctrl_o.space2 = (cnt_q <= 3'd2);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + {1'b0, ctrl_i.push0} + {1'b0, ctrl_i.push1};
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {2'b0, ctrl_i.push0} + {2'b0, ctrl_i.push1} - {2'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push0) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (ctrl_i.push1) begin
      mem_q[wr_ptr_q + 2'd1] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/key_report_tx_scheduler.sv =====
`default_nettype none

// Key report scheduler: queues combo and media key events (QUEUE_DEPTH
// entries) and paces them out on tick transactions: a combo is pressed for
// hold_ticks ticks and then released, and every release or nonzero media
// report is followed by gap_ticks ticks of silence. One input transaction is
// taken per clock; the results of an input are computed from its registered
// copy and written, at most two per input, into a four-entry result queue
// that drains one transaction per cycle while out_stall_i is low. The input
// stalls only while that result queue holds more than two entries. The event
// store has a write and a read port; its head entry is prefetched into a
// register with write forwarding. Configuration writes are always ready.
module key_report_tx_scheduler
  import krts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         command_i,
  input  wire logic                               link_up_i,
  input  wire logic [15:0]                        key_code_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [2:0]                              action_o,
  output logic [15:0]                             code_out_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        occupancy_o,
  output logic                                    last_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic                               cfg_index_i,
  input  wire logic [9:0]                         cfg_data_i
);

  localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
  localparam int unsigned OccWidth = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ResWidth = 3 + CodeWidth + OccWidth + 1;
  localparam logic [PtrWidth-1:0] LastIdx = PtrWidth'(QUEUE_DEPTH - 1);
  localparam logic [OccWidth-1:0] FullCnt = OccWidth'(QUEUE_DEPTH);

  logic [CntWidth-1:0] hold_ticks_q, gap_ticks_q;

  logic                 in_valid_q;
  cmd_e                 cmd_q;
  logic                 link_q;
  logic [CodeWidth-1:0] code_q;

  entry_t               mem_q [QUEUE_DEPTH];
  entry_t               head_q;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [OccWidth-1:0]  fill_q, fill_d;
  logic                 pend_q, pend_d;
  logic [CntWidth-1:0]  hold_q, hold_d;
  logic [CntWidth-1:0]  gap_q, gap_d;

  rq_ctrl_t             rq_in, rq_out;
  logic                 proc;
  logic                 mem_we;
  entry_t               wr_entry;
  action_e              act0, act1;
  logic [CodeWidth-1:0] code0, code1;
  logic [OccWidth-1:0]  occ0, occ1;
  logic                 last0;
  logic [ResWidth-1:0]  res0, res1, res_out;

  logic                 full, rel, pend1, deq;
  logic [CntWidth-1:0]  hold_dec, gap_dec, gap1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HoldReset;
      gap_ticks_q  <= GapReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i;
        CFG_GAP_TICKS:  gap_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign proc       = in_valid_q && rq_out.space2;
  assign in_stall_o = in_valid_q && !rq_out.space2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= cmd_e'(command_i);
      link_q <= link_up_i;
      code_q <= key_code_i;
    end
  end

  function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
    ptr_inc = (p == LastIdx) ? '0 : p + PtrWidth'(1);
  endfunction

  always_comb begin
    full     = (fill_q == FullCnt);
    wr_entry.media = (cmd_q == CMD_ENQ_MEDIA);
    wr_entry.code  = (cmd_q == CMD_ENQ_MEDIA) ? code_q : {8'd0, code_q[7:0]};
    hold_dec = hold_q - CntWidth'(hold_q != '0);
    gap_dec  = gap_q - CntWidth'(gap_q != '0);
    rel      = pend_q && (hold_dec == '0);
    pend1    = pend_q && !rel;
    gap1     = rel ? gap_ticks_q : gap_dec;
    deq      = !pend1 && (gap1 == '0) && (fill_q != '0);

    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    pend_d   = pend_q;
    hold_d   = hold_q;
    gap_d    = gap_q;
    mem_we   = 1'b0;
    rq_in    = '0;
    act0     = ACT_ENQ;
    code0    = wr_entry.code;
    occ0     = fill_q;
    last0    = 1'b1;
    act1     = ACT_PRESS;
    code1    = head_q.code;
    occ1     = fill_q - OccWidth'(1);

    if (proc) begin
      case (cmd_q)
        CMD_ENQ_COMBO, CMD_ENQ_MEDIA: begin
          rq_in.push0 = 1'b1;
          if (full) begin
            act0 = ACT_FULL;
          end else begin
            mem_we   = 1'b1;
            wr_ptr_d = ptr_inc(wr_ptr_q);
            fill_d   = fill_q + OccWidth'(1);
            occ0     = fill_q + OccWidth'(1);
          end
        end
        CMD_TICK: begin
          if (!link_q) begin
            rd_ptr_d    = '0;
            wr_ptr_d    = '0;
            fill_d      = '0;
            pend_d      = 1'b0;
            hold_d      = '0;
            gap_d       = '0;
            rq_in.push0 = pend_q;
            act0        = ACT_RELEASE;
            code0       = '0;
            occ0        = '0;
          end else begin
            pend_d = pend1;
            hold_d = hold_dec;
            gap_d  = gap1;
            if (deq) begin
              rd_ptr_d = ptr_inc(rd_ptr_q);
              fill_d   = fill_q - OccWidth'(1);
              if (!head_q.media) begin
                pend_d = 1'b1;
                hold_d = hold_ticks_q;
                act1   = ACT_PRESS;
              end else if (head_q.code != '0) begin
                gap_d  = gap_ticks_q;
                act1   = ACT_MEDIA;
              end
            end
            if (rel) begin
              rq_in.push0 = 1'b1;
              act0        = ACT_RELEASE;
              code0       = '0;
              occ0        = fill_q;
              if (deq && (!head_q.media || head_q.code != '0)) begin
                rq_in.push1 = 1'b1;
                last0       = 1'b0;
              end
            end else if (deq && (!head_q.media || head_q.code != '0)) begin
              rq_in.push0 = 1'b1;
              act0        = act1;
              code0       = head_q.code;
              occ0        = occ1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
    if (mem_we && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= wr_entry;
    end else begin
      head_q <= mem_q[rd_ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      pend_q   <= 1'b0;
      hold_q   <= '0;
      gap_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      pend_q   <= pend_d;
      hold_q   <= hold_d;
      gap_q    <= gap_d;
    end
  end

  assign res0 = {act0, code0, occ0, last0};
  assign res1 = {act1, code1, occ1, 1'b1};

  krts_result_fifo #(
    .Width (ResWidth)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rq_in),
    .ctrl_o      (rq_out),
    .data0_i     (res0),
    .data1_i     (res1),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_out)
  );

  assign action_o    = res_out[ResWidth-1 -: 3];
  assign code_out_o  = res_out[OccWidth+1 +: CodeWidth];
  assign occupancy_o = res_out[1 +: OccWidth];
  assign last_o      = res_out[0];

endmodule

`default_nettype wire

// ===== test/krts_sb_pkg.sv =====
package krts_sb_pkg;
  import krts_pkg::*;

  localparam int QueueDepth = 16;

  typedef struct packed {
    action_e     act;
    logic [15:0] code;
    logic [4:0]  occ;
    logic        last;
  } sched_report_t;

  class key_sched_scoreboard;
    entry_t        slots [QueueDepth];
    int            rd_ptr;
    int            wr_ptr;
    int            fill;
    bit            combo_down;
    logic [9:0]    hold_left;
    logic [9:0]    gap_left;
    logic [9:0]    hold_cfg;
    logic [9:0]    gap_cfg;
    sched_report_t expected_reports [$];
    int            errors;

    function new();
      clear_link();
      hold_cfg = HoldReset;
      gap_cfg  = GapReset;
      errors   = 0;
    endfunction

    function void clear_link();
      rd_ptr     = 0;
      wr_ptr     = 0;
      fill       = 0;
      combo_down = 1'b0;
      hold_left  = '0;
      gap_left   = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [9:0] value);
      if (idx == CFG_HOLD_TICKS) begin
        hold_cfg = value;
      end else begin
        gap_cfg = value;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function sched_report_t make_report(action_e act, logic [15:0] code);
      sched_report_t r;
      r.act  = act;
      r.code = code;
      r.occ  = 5'(fill);
      r.last = 1'b0;
      return r;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    function void note_input(cmd_e cmd, logic link, logic [15:0] key);
      sched_report_t res [2];
      entry_t        ent;
      int            n;
      bit            was_down;
      n = 0;
      if (cmd == CMD_ENQ_COMBO || cmd == CMD_ENQ_MEDIA) begin
        ent.media = (cmd == CMD_ENQ_MEDIA);
        ent.code  = ent.media ? key : {8'h00, key[7:0]};
        if (fill >= QueueDepth) begin
          res[0] = make_report(ACT_FULL, ent.code);
        end else begin
          slots[wr_ptr] = ent;
          wr_ptr = (wr_ptr + 1) % QueueDepth;
          fill++;
          res[0] = make_report(ACT_ENQ, ent.code);
        end
        n = 1;
      end else if (cmd == CMD_TICK) begin
        if (hold_left != 0) hold_left--;
        if (gap_left != 0) gap_left--;
        if (!link) begin
          was_down = combo_down;
          clear_link();
          if (was_down) begin
            res[0] = make_report(ACT_RELEASE, 16'h0000);
            n = 1;
          end
        end else begin
          if (combo_down && hold_left == 0) begin
            combo_down = 1'b0;
            gap_left   = gap_cfg;
            res[n]     = make_report(ACT_RELEASE, 16'h0000);
            n++;
          end
          if (!combo_down && gap_left == 0 && fill != 0) begin
            ent    = slots[rd_ptr];
            rd_ptr = (rd_ptr + 1) % QueueDepth;
            fill--;
            if (!ent.media) begin
              combo_down = 1'b1;
              hold_left  = hold_cfg;
              res[n]     = make_report(ACT_PRESS, {8'h00, ent.code[7:0]});
              n++;
            end else if (ent.code != 16'h0000) begin
              gap_left = gap_cfg;
              res[n]   = make_report(ACT_MEDIA, ent.code);
              n++;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        res[i].last = (i == n - 1);
        expected_reports.push_back(res[i]);
      end
    endfunction

    function void check_report(logic [2:0] act, logic [15:0] code, logic [4:0] occ,
                               logic last);
      sched_report_t e;
      if (expected_reports.size() == 0) begin
        report($sformatf("unexpected result action %0d code %h occupancy %0d",
                         act, code, occ));
        return;
      end
      e = expected_reports.pop_front();
      if (act !== e.act) report($sformatf("action got %0d expected %0d", act, e.act));
      if (code !== e.code) report($sformatf("code got %h expected %h", code, e.code));
      if (occ !== e.occ) report($sformatf("occupancy got %0d expected %0d", occ, e.occ));
      if (last !== e.last) report($sformatf("last got %b expected %b", last, e.last));
    endfunction
  endclass

endpackage

// ===== test/tb_key_report_tx_scheduler.sv =====
module tb_key_report_tx_scheduler;
  import krts_pkg::*;
  import krts_sb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 2000000;
  localparam int DrainCycles   = 10;
  localparam int HoldOffCycles = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  cmd_e        command   = CMD_TICK;
  logic        link_up   = 1'b0;
  logic [15:0] key_code  = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [15:0] code_out;
  logic [4:0]  occupancy;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_e    cfg_index = CFG_HOLD_TICKS;
  logic [9:0]  cfg_data  = '0;

  key_sched_scoreboard sb;

  int items_sent    = 0;
  bit sender_calm   = 1'b0;
  int holdoff_asked = 0;
  int holdoff_done  = 0;
  int holdoff_left  = 0;
  int stall_left    = 0;
  int calm_left     = 0;
  int cycle_count   = 0;

  key_report_tx_scheduler #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .command_i  (command),
    .link_up_i  (link_up),
    .key_code_i (key_code),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .action_o   (action),
    .code_out_o (code_out),
    .occupancy_o(occupancy),
    .last_o     (last),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(command, link_up, key_code);
      if (out_valid && !out_stall) sb.check_report(action, code_out, occupancy, last);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (holdoff_done != holdoff_asked) begin
      holdoff_done = holdoff_asked;
      holdoff_left = HoldOffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        calm_left = int'($urandom_range(30, 200));
      end else begin
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(input cmd_e c, input logic lk, input logic [15:0] k);
    int gap;
    in_valid <= 1'b1;
    command  <= c;
    link_up  <= lk;
    key_code <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic configure(input logic [9:0] hold, input logic [9:0] gap);
    cfg_reg_e   idx;
    logic [9:0] value;
    for (int i = 0; i < 2; i++) begin
      idx   = (i == 0) ? CFG_HOLD_TICKS : CFG_GAP_TICKS;
      value = (i == 0) ? hold : gap;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx, value);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(input int enq_pct, input int down_pct);
    int          r;
    cmd_e        c;
    logic        lk;
    logic [15:0] k;
    r = $urandom_range(0, 99);
    if (r < enq_pct) begin
      c = ($urandom_range(0, 1) != 0) ? CMD_ENQ_MEDIA : CMD_ENQ_COMBO;
    end else if (r < enq_pct + 2) begin
      c = CMD_UNUSED;
    end else begin
      c = CMD_TICK;
    end
    if (c == CMD_TICK) begin
      lk = (int'($urandom_range(0, 99)) >= down_pct);
    end else begin
      lk = 1'($urandom_range(0, 1));
    end
    case ($urandom_range(0, 9))
      0: k = 16'h0000;
      1: k = 16'hFFFF;
      2, 3: k = 16'($urandom_range(1, 255));
      default: k = 16'($urandom);
    endcase
    send_item(c, lk, k);
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    int per_event;
    int n_ev;
    int n_ticks;
    int kind;
    stop_at   = items_sent + budget;
    per_event = int'(sb.hold_cfg) + int'(sb.gap_cfg) + 2;
    while (items_sent < stop_at) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        n_ev = ($urandom_range(0, 7) == 0) ? int'($urandom_range(15, 22))
                                          : int'($urandom_range(1, 5));
        repeat (n_ev) random_item(100, 0);
        n_ticks = n_ev * per_event;
        if (n_ticks > 80) n_ticks = 80;
        repeat (n_ticks) random_item(4, 0);
      end else if (kind < 9) begin
        repeat ($urandom_range(5, 30)) random_item(35, 4);
      end else begin
        repeat ($urandom_range(3, 12)) random_item(25, 50);
      end
    end
  endtask

  task automatic run_settings(input logic [9:0] hold, input logic [9:0] gap,
                              input int budget, input bit with_holdoff);
    wait_idle();
    configure(hold, gap);
    if (with_holdoff) begin
      holdoff_asked <= holdoff_asked + 1;
      sender_calm = 1'b1;
      repeat (40) random_item(100, 0);
    end
    run_phase(budget);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_TICK, 1'b0, 16'h0000);
    send_item(CMD_UNUSED, 1'b1, 16'hFFFF);
    send_item(CMD_ENQ_COMBO, 1'b0, 16'hFFFF);
    send_item(CMD_ENQ_MEDIA, 1'b1, 16'h0000);
    send_item(CMD_ENQ_MEDIA, 1'b0, 16'hFFFF);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_TICK, 1'b0, 16'h0000);

    wait_idle();
    configure(10'd0, 10'd0);
    send_item(CMD_ENQ_COMBO, 1'b1, 16'h0000);
    send_item(CMD_ENQ_MEDIA, 1'b1, 16'h0000);
    send_item(CMD_ENQ_MEDIA, 1'b0, 16'h8001);
    send_item(CMD_ENQ_COMBO, 1'b1, 16'h1241);
    send_item(CMD_TICK, 1'b1, 16'hFFFF);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_ENQ_MEDIA, 1'b1, 16'hFFFF);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_ENQ_COMBO, 1'b0, 16'h00FF);
    send_item(CMD_TICK, 1'b1, 16'h0000);
    send_item(CMD_TICK, 1'b0, 16'h0000);
    send_item(CMD_ENQ_MEDIA, 1'b0, 16'h0001);
    send_item(CMD_TICK, 1'b0, 16'h0000);
    send_item(CMD_TICK, 1'b1, 16'h0000);

    run_settings(10'd14, 10'd8, 420, 1'b1);
    run_settings(10'd0, 10'd0, 400, 1'b0);
    run_settings(10'd1023, 10'd1023, 60, 1'b0);
    run_settings(10'd1, 10'd0, 250, 1'b0);
    run_settings(10'd0, 10'd1, 250, 1'b0);
    run_settings(10'd5, 10'd3, 300, 1'b0);
    run_settings(10'd1023, 10'd0, 40, 1'b0);
    run_settings(10'd0, 10'd1023, 40, 1'b0);
    run_settings(10'd2, 10'd1, 150, 1'b0);
    wait_idle();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== key_report_tx_scheduler.f =====
hw/rtl/krts_pkg.sv
hw/rtl/krts_result_fifo.sv
hw/rtl/key_report_tx_scheduler.sv
test/krts_sb_pkg.sv
test/tb_key_report_tx_scheduler.sv
